FILE: design/crcdf_pkg.sv
`default_nettype none

package crcdf_pkg;

    localparam int PAYLOAD_CAP = 512;
    localparam int POS_MAX     = 16 + PAYLOAD_CAP;
    localparam int POS_W       = $clog2(POS_MAX + 1);
    localparam int CMP_W       = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  HDR_MASK  = 8'b11011111;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_WINDOW = 3'd1,
        ST_LENGTH = 3'd2,
        ST_CRC    = 3'd3,
        ST_SIZE   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_MAX_WINDOW  = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [1:0]  pkt_type;
        logic        truncated_flag;
        logic [4:0]  window;
        logic [7:0]  seq_number;
        logic [15:0] payload_length;
        logic [31:0] time_stamp;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/crcdf_if.sv
`default_nettype none

interface crcdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface crcdf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [1:0]  pkt_type;
    logic        truncated_flag;
    logic [4:0]  window;
    logic [7:0]  seq_number;
    logic [15:0] payload_length;
    logic [31:0] time_stamp;

    modport source (
        output valid, output kind, output payload_byte, output status,
        output pkt_type, output truncated_flag, output window,
        output seq_number, output payload_length, output time_stamp,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input status,
        input pkt_type, input truncated_flag, input window,
        input seq_number, input payload_length, input time_stamp,
        output ready
    );
endinterface

interface crcdf_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/crcdf_queue.sv
`default_nettype none

module crcdf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crcdf_pkg::push_t push,
    output crcdf_pkg::res_t       head,
    output logic                  head_valid,
    input  wire logic             head_ready,
    output logic                  room
);
    import crcdf_pkg::*;

    res_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               pop;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    // a packet's last byte can push two transactions at once
    assign room       = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

FILE: design/crcdf_core.sv
`default_nettype none

module crcdf_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    crcdf_in_if.sink          pkt_in,
    crcdf_cfg_if.sink         cfg,
    input  wire logic         room,
    output crcdf_pkg::push_t  push
);
    import crcdf_pkg::*;

    // input register
    logic              valid_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic              consume;

    // configuration
    logic [4:0]        max_window_reg;
    logic [9:0]        max_payload_reg;

    // packet state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [31:0]       crc_reg;
    logic [31:0]       crc_next;
    logic [31:0]       rcrc_reg;
    logic [31:0]       rcrc_next;
    logic [7:0]        hb0_reg;
    logic [7:0]        hb0_next;
    logic [7:0]        seq_reg;
    logic [7:0]        seq_next;
    logic [15:0]       len_reg;
    logic [15:0]       len_next;
    logic [31:0]       stamp_reg;
    logic [31:0]       stamp_next;
    status_t           err_reg;
    status_t           err_next;

    // values after this byte
    logic [31:0]       crc_mid;
    logic [31:0]       rcrc_mid;
    logic [7:0]        hb0_mid;
    logic [7:0]        seq_mid;
    logic [15:0]       len_mid;
    logic [31:0]       stamp_mid;
    status_t           err_mid;
    status_t           status;
    logic [31:0]       crc_upd;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  len_mid_ext;
    logic              emit;
    logic              size_ok;
    res_t              data_res;
    res_t              rep_res;

    assign consume      = valid_reg && room;
    assign pkt_in.ready = !valid_reg || room;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pkt_in.ready)
        begin
            valid_reg <= pkt_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_in.valid && pkt_in.ready)
        begin
            data_reg <= pkt_in.data_byte;
            last_reg <= pkt_in.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_window_reg  <= 5'd31;
            max_payload_reg <= 10'd512;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAX_WINDOW:  max_window_reg  <= cfg.data[4:0];
                REG_MAX_PAYLOAD: max_payload_reg <= cfg.data;
                default:         max_window_reg  <= max_window_reg;
            endcase
        end
    end

    always_comb
    begin
        pos_ext     = CMP_W'(pos_reg);
        len_ext     = CMP_W'(len_reg);
        crc_upd     = crc_byte(crc_reg, (pos_reg == '0) ? (data_reg & HDR_MASK) : data_reg);
        crc_mid     = crc_reg;
        rcrc_mid    = rcrc_reg;
        hb0_mid     = hb0_reg;
        seq_mid     = seq_reg;
        len_mid     = len_reg;
        stamp_mid   = stamp_reg;
        err_mid     = err_reg;
        emit        = 1'b0;

        // header field capture
        priority if (pos_reg == POS_W'(0))
        begin
            hb0_mid = data_reg;
            if (err_reg == ST_OK && data_reg[4:0] > max_window_reg)
            begin
                err_mid = ST_WINDOW;
            end
        end
        else if (pos_reg == POS_W'(1))
        begin
            seq_mid = data_reg;
        end
        else if (pos_reg == POS_W'(2))
        begin
            len_mid = {data_reg, 8'h00};
        end
        else if (pos_reg == POS_W'(3))
        begin
            len_mid = {len_reg[15:8], data_reg};
            if (err_reg == ST_OK && (len_mid > 16'(max_payload_reg)
                                     || len_mid > 16'(PAYLOAD_CAP)))
            begin
                err_mid = ST_LENGTH;
            end
        end
        else if (pos_reg <= POS_W'(7))
        begin
            stamp_mid = {stamp_reg[23:0], data_reg};
        end
        else
        begin
            stamp_mid = stamp_reg;
        end

        // CRC section
        priority if (pos_reg <= POS_W'(7))
        begin
            crc_mid = crc_upd;
        end
        else if (pos_reg <= POS_W'(11))
        begin
            rcrc_mid = {rcrc_reg[23:0], data_reg};
            if (pos_reg == POS_W'(11))
            begin
                if (err_mid == ST_OK && (~crc_reg) != rcrc_mid)
                begin
                    err_mid = ST_CRC;
                end
                crc_mid = CRC_INIT;
            end
        end
        else if (pos_ext < len_ext + CMP_W'(12))
        begin
            crc_mid = crc_upd;
            emit    = (err_reg == ST_OK);
        end
        else if (len_reg != '0 && pos_ext < len_ext + CMP_W'(16))
        begin
            rcrc_mid = {rcrc_reg[23:0], data_reg};
            if (pos_ext == len_ext + CMP_W'(15) && err_reg == ST_OK
                && (~crc_reg) != rcrc_mid)
            begin
                err_mid = ST_CRC;
            end
        end
        else
        begin
            rcrc_mid = rcrc_reg;
        end

        // end-of-packet status: size check only when nothing else failed
        len_mid_ext = CMP_W'(len_mid);
        if (len_mid == '0)
        begin
            size_ok = (pos_ext == CMP_W'(11));
        end
        else
        begin
            size_ok = (pos_ext == len_mid_ext + CMP_W'(11))
                   || (pos_ext == len_mid_ext + CMP_W'(15));
        end
        if (err_mid != ST_OK)
        begin
            status = err_mid;
        end
        else
        begin
            status = size_ok ? ST_OK : ST_SIZE;
        end
    end

    always_comb
    begin
        data_res              = '0;
        data_res.kind         = KIND_PAYLOAD;
        data_res.payload_byte = data_reg;
        data_res.status       = ST_OK;

        rep_res.kind           = KIND_REPORT;
        rep_res.payload_byte   = 8'h00;
        rep_res.status         = status;
        rep_res.pkt_type       = hb0_mid[7:6];
        rep_res.truncated_flag = hb0_mid[5];
        rep_res.window         = hb0_mid[4:0];
        rep_res.seq_number     = seq_mid;
        rep_res.payload_length = len_mid;
        rep_res.time_stamp     = stamp_mid;

        push.count  = 2'd0;
        push.first  = emit ? data_res : rep_res;
        push.second = rep_res;
        if (consume)
        begin
            push.count = {1'b0, emit} + {1'b0, last_reg};
        end
    end

    always_comb
    begin
        if (last_reg)
        begin
            pos_next   = '0;
            crc_next   = CRC_INIT;
            rcrc_next  = '0;
            hb0_next   = '0;
            seq_next   = '0;
            len_next   = '0;
            stamp_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            // hold at the saturation point, never a valid end position
            pos_next   = (pos_reg < POS_W'(POS_MAX)) ? pos_reg + POS_W'(1) : pos_reg;
            crc_next   = crc_mid;
            rcrc_next  = rcrc_mid;
            hb0_next   = hb0_mid;
            seq_next   = seq_mid;
            len_next   = len_mid;
            stamp_next = stamp_mid;
            err_next   = err_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= '0;
            hb0_reg   <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            stamp_reg <= '0;
            err_reg   <= ST_OK;
        end
        else if (consume)
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            hb0_reg   <= hb0_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            stamp_reg <= stamp_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/crc_checked_packet_deframer_unit.sv
`default_nettype none

// channel  direction  transaction
// pkt_in   in         one packet byte, last marks the final byte
// res_out  out        payload byte (kind 0) or end-of-packet report (kind 1)
// cfg      in         register write: index 0 max_window, 1 max_payload
//
// One byte is taken per cycle while the queue has room; it is processed from the input register,
// with a byte-wide CRC-32 update, and its results land in a four-entry queue.
// A last payload byte yields two transactions; pkt_in stalls only when the queue
// has fewer than two free slots.
// Reset clears the packet state, the queue, and loads max_window 31, max_payload 512.

module crc_checked_packet_deframer_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    crcdf_in_if.sink     pkt_in,
    crcdf_out_if.source  res_out,
    crcdf_cfg_if.sink    cfg
);
    import crcdf_pkg::*;

    push_t  push;
    res_t   head;
    logic   head_valid;
    logic   room;

    crcdf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt_in (pkt_in),
        .cfg    (cfg),
        .room   (room),
        .push   (push)
    );

    crcdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .head       (head),
        .head_valid (head_valid),
        .head_ready (res_out.ready),
        .room       (room)
    );

    assign res_out.valid          = head_valid;
    assign res_out.kind           = head.kind;
    assign res_out.payload_byte   = head.payload_byte;
    assign res_out.status         = head.status;
    assign res_out.pkt_type       = head.pkt_type;
    assign res_out.truncated_flag = head.truncated_flag;
    assign res_out.window         = head.window;
    assign res_out.seq_number     = head.seq_number;
    assign res_out.payload_length = head.payload_length;
    assign res_out.time_stamp     = head.time_stamp;

endmodule

`default_nettype wire

FILE: tb/crcdf_deframe_checker.sv
module crcdf_deframe_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_data,
    input  wire logic        in_last,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [2:0]  status,
    input  wire logic [1:0]  pkt_type,
    input  wire logic        truncated_flag,
    input  wire logic [4:0]  window,
    input  wire logic [7:0]  seq_number,
    input  wire logic [15:0] payload_length,
    input  wire logic [31:0] time_stamp,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    output int               fail_count,
    output int               outstanding,
    output int               payloads_checked,
    output int               reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import crcdf_pkg::*;

    logic [4:0]  lim_window;
    logic [9:0]  lim_payload;

    int unsigned frame_pos;
    logic [31:0] crc_acc;
    logic [31:0] crc_seen;
    logic [7:0]  byte0_cap;
    logic [7:0]  seq_cap;
    logic [15:0] len_cap;
    logic [31:0] stamp_cap;
    status_t     first_err;

    res_t        predicted_out[$];
    int          errs;
    int          n_payload;
    int          n_report;

    // Bit-serial reflected CRC-32, LSB of the byte first.
    function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[31:1]};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic clear_frame();
        frame_pos = 0;
        crc_acc   = '1;
        crc_seen  = '0;
        byte0_cap = '0;
        seq_cap   = '0;
        len_cap   = '0;
        stamp_cap = '0;
        first_err = ST_OK;
    endtask

    task automatic deframe_step(logic [7:0] b, logic lst);
        int unsigned pos;
        int unsigned len;
        res_t        r;
        status_t     st;
        logic        ok;
        pos = frame_pos;

        unique case (pos)
            0:
            begin
                byte0_cap = b;
                if (first_err == ST_OK && b[4:0] > lim_window)
                    first_err = ST_WINDOW;
            end
            1: seq_cap = b;
            2: len_cap = {b, 8'h00};
            3:
            begin
                len_cap[7:0] = b;
                if (first_err == ST_OK &&
                    (len_cap > lim_payload || len_cap > PAYLOAD_CAP))
                    first_err = ST_LENGTH;
            end
            4, 5, 6, 7: stamp_cap = {stamp_cap[23:0], b};
            default: ;
        endcase

        if (pos <= 7)
        begin
            crc_acc = crc32_step(crc_acc, (pos == 0) ? (b & HDR_MASK) : b);
        end
        else if (pos <= 11)
        begin
            crc_seen = {crc_seen[23:0], b};
            if (pos == 11)
            begin
                if (first_err == ST_OK && ~crc_acc != crc_seen)
                    first_err = ST_CRC;
                crc_acc = '1;
            end
        end
        else
        begin
            len = len_cap;
            if (pos < 12 + len)
            begin
                crc_acc = crc32_step(crc_acc, b);
                // drop passthrough once an error is latched
                if (first_err == ST_OK)
                begin
                    r              = '0;
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    predicted_out.push_back(r);
                end
            end
            else if (len != 0 && pos < 16 + len)
            begin
                crc_seen = {crc_seen[23:0], b};
                if (pos == 15 + len && first_err == ST_OK && ~crc_acc != crc_seen)
                    first_err = ST_CRC;
            end
        end

        if (lst)
        begin
            len = len_cap;
            st  = first_err;
            if (st == ST_OK)
            begin
                if (len == 0)
                    ok = (pos == 11);
                else
                    ok = (pos == 11 + len) || (pos == 15 + len);
                st = ok ? ST_OK : ST_SIZE;
            end
            r                = '0;
            r.kind           = KIND_REPORT;
            r.status         = st;
            r.pkt_type       = byte0_cap[7:6];
            r.truncated_flag = byte0_cap[5];
            r.window         = byte0_cap[4:0];
            r.seq_number     = seq_cap;
            r.payload_length = len_cap;
            r.time_stamp     = stamp_cap;
            predicted_out.push_back(r);
            clear_frame();
        end
        else if (pos < POS_MAX)
        begin
            frame_pos = pos + 1;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errs++;
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t want;
        if (!rst_n)
        begin
            lim_window  = 5'd31;
            lim_payload = 10'd512;
            clear_frame();
            predicted_out.delete();
            errs      = 0;
            n_payload = 0;
            n_report  = 0;
            fail_count       <= 0;
            outstanding      <= 0;
            payloads_checked <= 0;
            reports_checked  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_WINDOW)
                    lim_window = cfg_data[4:0];
                else
                    lim_payload = cfg_data;
            end

            // pop before push: a result never leaves in the cycle its byte is taken
            if (out_valid && out_ready)
            begin
                if (predicted_out.size() == 0)
                begin
                    errs++;
                    $error("result transaction with nothing predicted: kind %0d", kind);
                end
                else
                begin
                    want = predicted_out.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("status", want.status, status);
                    check_field("pkt_type", want.pkt_type, pkt_type);
                    check_field("truncated_flag", want.truncated_flag, truncated_flag);
                    check_field("window", want.window, window);
                    check_field("seq_number", want.seq_number, seq_number);
                    check_field("payload_length", want.payload_length, payload_length);
                    check_field("time_stamp", want.time_stamp, time_stamp);
                    if (want.kind == KIND_REPORT)
                        n_report++;
                    else
                        n_payload++;
                end
            end

            if (in_valid && in_ready)
                deframe_step(in_data, in_last);

            fail_count       <= errs;
            outstanding      <= predicted_out.size();
            payloads_checked <= n_payload;
            reports_checked  <= n_report;
        end
    end

endmodule

FILE: tb/tb_crc_checked_packet_deframer_unit.sv
module tb_crc_checked_packet_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import crcdf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 25;

    logic clk = 1'b0;
    logic rst_n;

    int cycles     = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int settings_used = 1;
    int burst_left = 0;

    logic [4:0] cur_win;
    logic [9:0] cur_pay;
    logic [7:0] frame_q[$];

    int fail_count;
    int outstanding;
    int payloads_checked;
    int reports_checked;

    crcdf_in_if  pkt_if ();
    crcdf_out_if res_if ();
    crcdf_cfg_if cfg_if ();

    crc_checked_packet_deframer_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pkt_if),
        .res_out (res_if),
        .cfg     (cfg_if)
    );

    crcdf_deframe_checker u_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (pkt_if.valid),
        .in_ready         (pkt_if.ready),
        .in_data          (pkt_if.data_byte),
        .in_last          (pkt_if.last),
        .out_valid        (res_if.valid),
        .out_ready        (res_if.ready),
        .kind             (res_if.kind),
        .payload_byte     (res_if.payload_byte),
        .status           (res_if.status),
        .pkt_type         (res_if.pkt_type),
        .truncated_flag   (res_if.truncated_flag),
        .window           (res_if.window),
        .seq_number       (res_if.seq_number),
        .payload_length   (res_if.payload_length),
        .time_stamp       (res_if.time_stamp),
        .cfg_valid        (cfg_if.valid),
        .cfg_ready        (cfg_if.ready),
        .cfg_index        (cfg_if.index),
        .cfg_data         (cfg_if.data),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .payloads_checked (payloads_checked),
        .reports_checked  (reports_checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall modes, plus one long hold-off mid-run to back up the block.
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && bytes_sent >= 300)
                begin
                    held = 1'b1;
                    res_if.ready <= 1'b0;
                    repeat (400) @(posedge clk);
                end
                unique case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 1) == 1);
                    2: res_if.ready <= ($urandom_range(0, 9) != 0);
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= b;
        pkt_if.last      <= lst;
        @(posedge clk);
        while (!pkt_if.ready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic build_frame(logic [7:0] h0, logic [7:0] seq, logic [15:0] lenf,
                               logic [31:0] stamp, int npay, logic with_crc,
                               logic bad_hdr, logic bad_pay);
        logic [31:0] c;
        logic [7:0]  hdr[8];
        logic [7:0]  pb;
        frame_q.delete();
        hdr = '{h0, seq, lenf[15:8], lenf[7:0],
                stamp[31:24], stamp[23:16], stamp[15:8], stamp[7:0]};
        c = '1;
        for (int i = 0; i < 8; i++)
        begin
            frame_q.push_back(hdr[i]);
            c = crc_byte(c, (i == 0) ? (hdr[i] & HDR_MASK) : hdr[i]);
        end
        c = ~c;
        if (bad_hdr)
            c = c ^ (32'h1 << $urandom_range(0, 31));
        frame_q.push_back(c[31:24]);
        frame_q.push_back(c[23:16]);
        frame_q.push_back(c[15:8]);
        frame_q.push_back(c[7:0]);
        c = '1;
        for (int i = 0; i < npay; i++)
        begin
            pb = 8'($urandom);
            frame_q.push_back(pb);
            c = crc_byte(c, pb);
        end
        if (with_crc)
        begin
            c = ~c;
            if (bad_pay)
                c = c ^ (32'h1 << $urandom_range(0, 31));
            frame_q.push_back(c[31:24]);
            frame_q.push_back(c[23:16]);
            frame_q.push_back(c[15:8]);
            frame_q.push_back(c[7:0]);
        end
    endtask

    // Well-formed frames with random content, mixed with corrupted frames and noise.
    task automatic random_frame();
        int          r;
        int          sel;
        int          lim;
        int          len;
        int          npay;
        int          cut;
        logic [7:0]  h0;
        logic        crc_on;
        r   = $urandom_range(0, 99);
        lim = (cur_pay > 512) ? 512 : cur_pay;
        if (r >= 90)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
            return;
        end
        h0 = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            h0[4:0] = 5'($urandom_range(0, cur_win));
        sel = $urandom_range(0, 19);
        if (sel < 12)
            len = $urandom_range(0, (lim < 12) ? lim : 12);
        else if (sel < 16)
            len = $urandom_range(0, (lim < 40) ? lim : 40);
        else if (sel < 19)
            len = lim + $urandom_range(1, 3);
        else
            len = $urandom_range(0, 65535);
        npay   = (len <= 64) ? len : $urandom_range(0, 8);
        crc_on = (len != 0) && ($urandom_range(0, 1) == 1);
        build_frame(h0, 8'($urandom), len[15:0], $urandom, npay, crc_on,
                    (r >= 65 && r < 73), (r >= 73 && r < 80 && crc_on));
        if (r >= 80 && r < 86)
        begin
            cut = $urandom_range(1, frame_q.size() - 1);
            repeat (cut) void'(frame_q.pop_back());
        end
        else if (r >= 86 && r < 90)
        begin
            repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
        end
    endtask

    task automatic write_limits(logic [4:0] w, logic [9:0] p);
        logic [31:0] junk;
        junk = $urandom;
        // upper bits of the window write are don't-care
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_MAX_WINDOW;
        cfg_if.data  <= {junk[4:0], w};
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.index <= REG_MAX_PAYLOAD;
        cfg_if.data  <= p;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        cur_win = w;
        cur_pay = p;
    endtask

    // the outstanding count is registered in the checker, so the value seen at the last accepting edge is stale
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int target;
        logic [4:0] w;
        logic [9:0] p;
        rst_n            <= 1'b0;
        pkt_if.valid     <= 1'b0;
        pkt_if.data_byte <= '0;
        pkt_if.last      <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= REG_MAX_WINDOW;
        cfg_if.data      <= '0;
        cur_win = 5'd31;
        cur_pay = 10'd512;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones header, empty payload, under reset limits
        build_frame(8'hFF, 8'hFF, 16'h0000, 32'hFFFFFFFF, 0, 1'b0, 1'b0, 1'b0);
        send_frame();
        // single-byte frame ends inside the header
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        // all-zero header, one payload byte, no payload CRC
        build_frame(8'h00, 8'h00, 16'h0001, 32'h00000000, 1, 1'b0, 1'b0, 1'b0);
        send_frame();
        pkt_if.valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            unique case (ph)
                0:
                begin
                    w = 5'd0;
                    p = 10'd0;
                end
                1:
                begin
                    w = 5'd31;
                    p = 10'd1023;
                end
                3:
                begin
                    w = 5'd7;
                    p = 10'd16;
                end
                5:
                begin
                    w = 5'd31;
                    p = 10'd512;
                end
                default:
                begin
                    w = 5'($urandom_range(0, 31));
                    p = 10'($urandom_range(0, 1023));
                end
            endcase
            write_limits(w, p);
            settings_used++;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                random_frame();
                send_frame();
            end
            if (ph == 5)
            begin
                // largest legal payload with its CRC, then run on so the position saturates
                build_frame(8'h1F, 8'($urandom), 16'd512, $urandom, 512, 1'b1, 1'b0, 1'b0);
                repeat (3) frame_q.push_back(8'($urandom));
                send_frame();
            end
            pkt_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d frames (%0d bytes) under %0d limit settings", frames_sent,
                 bytes_sent, settings_used);
        $display("Checked %0d passthrough bytes and %0d end-of-frame reports",
                 payloads_checked, reports_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
